@@ hdl/d7s_pkg.sv @@
package d7s_pkg;

   localparam int VALUE_W    = 32;
   localparam int MAG_W      = VALUE_W - 1;
   localparam int NUM_BCD    = 10;
   localparam int BCD_W      = 4 * NUM_BCD;
   localparam int MAX_DIGITS = 10;
   // Digits that are actually kept; no positive 32-bit value has more than ten.
   localparam int CAP        = (MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD;
   localparam int PTR_W      = 4;
   localparam int CNT_W      = 5;
   localparam int SEG_W      = 7;
   localparam int RSP_DATA_W = 16;

   typedef logic [3:0]       digit_type;
   typedef logic [SEG_W-1:0] seg_type;
   typedef logic [BCD_W-1:0] bcd_type;

   // Segment A in bit 0 through segment G in bit 6, one means lit.
   function automatic seg_type seg_of(input digit_type d);
      seg_type s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

   // True when every BCD digit of the word holds a value from 0 to 9.
   function automatic logic bcd_ok(input bcd_type b);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < NUM_BCD; i++) begin
         if (b[4*i +: 4] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

@@ hdl/d7s_dabble_step.sv @@
// One shift-and-add-three step: every digit of five or more gets three added,
// then the BCD word shifts left by one and takes the next binary bit.
module d7s_dabble_step (
   input  d7s_pkg::bcd_type bcd_i,
   input  logic             bit_i,
   output d7s_pkg::bcd_type bcd_o
);

   d7s_pkg::bcd_type adj;

   always_comb begin
      for (int i = 0; i < d7s_pkg::NUM_BCD; i++) begin
         if (bcd_i[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_i[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_i[4*i +: 4];
         end
      end
   end

   assign bcd_o = {adj[d7s_pkg::BCD_W-2:0], bit_i};

endmodule

@@ hdl/decimal_digits_to_seven_segment_top.sv @@
// Channel  Direction  Ports                        Contents
// req      in         req_tvalid/tready/tdata      signed 32-bit value
// rsp      out        rsp_tvalid/tready/tdata/tlast digit, segments; tlast on final digit
//
// A positive value is taken and converted by the shared shift-and-add-three
// step, one magnitude bit per step; leading zeros are then skipped and each
// digit word is registered. Zero and negative values are taken and give no
// words. Reset is synchronous and active high; it idles the sequencer and
// drops rsp_tvalid. A result stall holds the emit phase; req_tready is low
// until the last word is registered.
module decimal_digits_to_seven_segment_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] digit, [10:4] segments, [15:11] zero
   output logic        rsp_tlast    // last
);

   typedef enum logic [1:0] {IDLE, CONV, EMIT} state_type;

   state_type                        state_ff, state_in;
   logic [d7s_pkg::MAG_W-1:0]        bin_ff, bin_in;
   d7s_pkg::bcd_type                 bcd_ff, bcd_in, bcd_step;
   logic [d7s_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [d7s_pkg::PTR_W-1:0]        ptr_ff, ptr_in;
   logic                             lead_ff, lead_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   d7s_pkg::digit_type               rsp_digit_ff, rsp_digit_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             req_accept;
   logic                             out_free;
   logic                             high_zero;
   d7s_pkg::digit_type               cur_digit;

   // The shared conversion unit; the top bit of the magnitude shifts in first.
   d7s_dabble_step u_step (
      .bcd_i (bcd_ff),
      .bit_i (bin_ff[d7s_pkg::MAG_W-1]),
      .bcd_o (bcd_step)
   );

   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cur_digit  = bcd_ff[4*ptr_ff +: 4];

   // Leading zeros may only be dropped when nothing was cut off above the kept
   // digits; otherwise all kept digits are shown, zeros included.
   always_comb begin
      high_zero = 1'b1;
      for (int i = 0; i < d7s_pkg::NUM_BCD; i++) begin
         if (i >= d7s_pkg::CAP && bcd_ff[4*i +: 4] != 4'd0) begin
            high_zero = 1'b0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      lead_in      = lead_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         IDLE: begin
            // Bit 31 clear and a nonzero word: a positive value to convert.
            if (req_accept && !req_tdata[31] && req_tdata[30:0] != '0) begin
               bin_in   = req_tdata[d7s_pkg::MAG_W-1:0];
               bcd_in   = '0;
               cnt_in   = d7s_pkg::CNT_W'(d7s_pkg::MAG_W - 1);
               state_in = CONV;
            end
         end
         CONV: begin
            bcd_in = bcd_step;
            bin_in = {bin_ff[d7s_pkg::MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               ptr_in   = d7s_pkg::PTR_W'(d7s_pkg::CAP - 1);
               lead_in  = 1'b1;
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (lead_ff && high_zero && cur_digit == 4'd0) begin
               ptr_in = ptr_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = cur_digit;
               rsp_last_in  = (ptr_ff == '0);
               lead_in      = 1'b0;
               if (ptr_ff == '0) begin
                  state_in = IDLE;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      cnt_ff       <= cnt_in;
      ptr_ff       <= ptr_in;
      lead_ff      <= lead_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(d7s_pkg::RSP_DATA_W - d7s_pkg::SEG_W - 4){1'b0}},
                        d7s_pkg::seg_of(rsp_digit_ff), rsp_digit_ff};

   // A positive value always starts a conversion.
   a_start_conv: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tdata[31] && req_tdata[30:0] != '0) |=> (state_ff == CONV))
      else $error("positive value did not start a conversion");

   // The shift-and-add-three step must keep every BCD digit in range.
   a_bcd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV || state_ff == EMIT) |-> d7s_pkg::bcd_ok(bcd_ff))
      else $error("BCD digit out of range");

   // A word presented on the result side always carries a decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] <= 4'd9))
      else $error("result digit out of range");

   // A word offered on the result side stays unchanged until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result word changed while stalled");

endmodule

@@ verif/decimal_digits_to_seven_segment_top_test.sv @@
`timescale 1ns / 100ps

// One digit word as it should leave the block.
typedef struct packed {
   d7s_pkg::digit_type digit;
   d7s_pkg::seg_type   segments;
   logic               last;
} digit_word_type;

class digit_scoreboard;
   digit_word_type expected_words[$];
   int unsigned    mismatches;

   function new();
      mismatches = 0;
   endfunction

   // Segment A in bit 0 up to segment G in bit 6, lit when one.
   function d7s_pkg::seg_type glyph(input d7s_pkg::digit_type d);
      case (d)
         4'd0:    return 7'b0111111;
         4'd1:    return 7'b0000110;
         4'd2:    return 7'b1011011;
         4'd3:    return 7'b1001111;
         4'd4:    return 7'b1100110;
         4'd5:    return 7'b1101101;
         4'd6:    return 7'b1111101;
         4'd7:    return 7'b0000111;
         4'd8:    return 7'b1111111;
         4'd9:    return 7'b1101111;
         default: return 7'b0000000;
      endcase
   endfunction

   function int pending();
      return expected_words.size();
   endfunction

   // Splits an accepted value into its digit words, most significant first.
   function void note_value(input logic [31:0] value);
      logic [31:0]        rest;
      d7s_pkg::digit_type digits [0:19];
      int                 count;
      int                 keep;
      digit_word_type     w;
      keep = d7s_pkg::MAX_DIGITS;
      if (keep < 1) keep = 1;
      if (keep > 20) keep = 20;
      if (value[31] || value == 32'd0) return;
      rest  = value;
      count = 0;
      while (rest != 32'd0 && count < keep) begin
         digits[count] = d7s_pkg::digit_type'(rest % 32'd10);
         rest          = rest / 32'd10;
         count++;
      end
      for (int i = count - 1; i >= 0; i--) begin
         w.digit    = digits[i];
         w.segments = glyph(digits[i]);
         w.last     = (i == 0);
         expected_words.push_back(w);
      end
   endfunction

   function void check_word(input logic [15:0] data, input logic tlast);
      digit_word_type want;
      if (expected_words.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected digit word, expected none, got data %h last %b",
                  $time, data, tlast);
         return;
      end
      want = expected_words.pop_front();
      if (data[3:0] !== want.digit) begin
         mismatches++;
         $display("%0t: digit mismatch, expected %0d, got %0d", $time, want.digit, data[3:0]);
      end
      if (data[10:4] !== want.segments) begin
         mismatches++;
         $display("%0t: segments mismatch, expected %b, got %b",
                  $time, want.segments, data[10:4]);
      end
      if (tlast !== want.last) begin
         mismatches++;
         $display("%0t: last mismatch, expected %b, got %b", $time, want.last, tlast);
      end
      if (data[15:11] !== 5'b0) begin
         mismatches++;
         $display("%0t: padding mismatch, expected 00000, got %b", $time, data[15:11]);
      end
   endfunction
endclass

module decimal_digits_to_seven_segment_top_test;

   // Longest run of cycles in which neither channel moves a word before the run
   // is declared hung.
   localparam int STUCK_LIMIT   = 1000;
   // Cycles allowed after the last expected word for stray words to show up.
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_VALUES = 140;

   // Directed values: the extremes of the field, every digit, internal zeros,
   // zero itself and the negative range including its most negative value.
   localparam int NUM_CORNERS = 20;
   localparam logic [31:0] CORNER_VALUES [NUM_CORNERS] = '{
      32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd7,
      32'd1234567890, 32'd987654321, 32'd1000000000, 32'd1010101010,
      32'd2000000000, 32'd1999999999, 32'h7FFF_FFFF, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE,
      32'd4294967, 32'd2147483640
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = 32'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   digit_scoreboard board;
   bit              quiet = 1'b0;   // when set, neither side idles
   int unsigned     stuck_cycles = 0;

   decimal_digits_to_seven_segment_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Either side takes an idle cycle about seven times in a hundred, except
   // during the quiet stretch.
   function automatic bit idle_now();
      return !quiet && ($urandom_range(0, 99) < 7);
   endfunction

   // A positive value with a chosen number of decimal digits, so that short
   // and long runs of words turn up in roughly equal measure.
   function automatic logic [31:0] value_of_length(input int len);
      longint unsigned lo;
      longint unsigned hi;
      lo = 1;
      for (int i = 1; i < len; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'd2147483647) hi = 64'd2147483647;
      return $urandom_range(32'(hi), 32'(lo));
   endfunction

   // Presents one value and returns at the edge at which it is accepted. The
   // valid stays high afterwards, so that back-to-back values need no gap; the
   // next call or the caller lowers it if a gap is wanted.
   task automatic send_value(input logic [31:0] value);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      board.note_value(value);
   endtask

   // Holds the sender off until every word that has been predicted has arrived.
   task automatic drain_words();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // The result side: every accepted word is checked against the oldest
   // expectation, and the ready for the next cycle is chosen at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_word(rsp_tdata, rsp_tlast);
      end
      rsp_tready <= !idle_now();
   end

   // Watchdog: the run is hung if neither channel moves a word for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int          pick;
      logic [31:0] value;
      board = new();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed values first.
      for (int i = 0; i < NUM_CORNERS; i++) begin
         send_value(CORNER_VALUES[i]);
      end
      drain_words();

      // Random values: mostly positive values of every length, with some zero
      // and negative ones, which the block takes and ignores.
      for (int n = 0; n < RANDOM_VALUES; n++) begin
         quiet = (n >= 40 && n < 80);
         if (n == 100) begin
            drain_words();
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            value = value_of_length($urandom_range(1, 10));
         end else if (pick < 85) begin
            value = $urandom();
         end else if (pick < 95) begin
            value = {1'b1, 31'($urandom())};
         end else begin
            value = 32'd0;
         end
         send_value(value);
      end
      quiet = 1'b0;

      // Wait for every predicted word, then give stray words time to appear.
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
